// ----- rtl/vfpl_pkg.sv -----
`default_nettype none

package vfpl_pkg;

  // Fixed field widths
  localparam int unsigned FMT_W   = 5;
  localparam int unsigned DIM_W   = 15;
  localparam int unsigned LINE_W  = 17;
  localparam int unsigned ROWS_W  = 15;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned PLANE_W = 2;
  localparam int unsigned ALGN_W  = 4;

  // Width and height are clipped to this before use
  localparam logic [DIM_W-1:0] MAX_DIM = 15'd16384;

  // Alignment exponent is clipped to this
  localparam logic [ALGN_W-1:0] ALIGN_LOG2_MAX = 4'd12;
  localparam logic [ALGN_W-1:0] ALIGN_LOG2_RST = 4'd5;

  localparam logic [PLANE_W-1:0] LAST_PLANE = 2'd3;

  // V210 divide by three: floor(y * V210_RECIP / 2^V210_SHIFT) for y < 8192
  localparam logic [11:0] V210_RECIP = 12'd2731;
  localparam int unsigned V210_SHIFT = 13;

  typedef enum logic [FMT_W-1:0] {
    FMT_NONE = 5'd0,  FMT_I420 = 5'd1,  FMT_NV12 = 5'd2,  FMT_YVYU = 5'd3,
    FMT_YUY2 = 5'd4,  FMT_UYVY = 5'd5,  FMT_RGBA = 5'd6,  FMT_BGRA = 5'd7,
    FMT_BGRX = 5'd8,  FMT_Y800 = 5'd9,  FMT_I444 = 5'd10, FMT_BGR3 = 5'd11,
    FMT_I422 = 5'd12, FMT_I40A = 5'd13, FMT_I42A = 5'd14, FMT_YUVA = 5'd15,
    FMT_AYUV = 5'd16, FMT_I010 = 5'd17, FMT_P010 = 5'd18, FMT_I210 = 5'd19,
    FMT_I412 = 5'd20, FMT_YA2L = 5'd21, FMT_P216 = 5'd22, FMT_P416 = 5'd23,
    FMT_V210 = 5'd24, FMT_R10L = 5'd25
  } format_code_t;

  // Bytes per line as a function of width
  typedef enum logic [2:0] {
    LK_NONE, LK_FULL, LK_HALF, LK_DOUBLE, LK_TRIPLE, LK_QUAD, LK_V210
  } line_kind_t;

  // Lines per plane as a function of height
  typedef enum logic [1:0] {
    HK_NONE, HK_FULL, HK_HALF
  } height_kind_t;

  typedef struct packed {
    line_kind_t   lk;
    height_kind_t hk;
  } plane_code_t;

  typedef plane_code_t [3:0] format_planes_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_bytes;
    logic [ROWS_W-1:0] rows;
  } line_geom_t;

  localparam plane_code_t PC_NONE = '{lk: LK_NONE,   hk: HK_NONE};
  localparam plane_code_t PC_F    = '{lk: LK_FULL,   hk: HK_FULL};
  localparam plane_code_t PC_F_HH = '{lk: LK_FULL,   hk: HK_HALF};
  localparam plane_code_t PC_H    = '{lk: LK_HALF,   hk: HK_FULL};
  localparam plane_code_t PC_H_HH = '{lk: LK_HALF,   hk: HK_HALF};
  localparam plane_code_t PC_D    = '{lk: LK_DOUBLE, hk: HK_FULL};
  localparam plane_code_t PC_D_HH = '{lk: LK_DOUBLE, hk: HK_HALF};
  localparam plane_code_t PC_T    = '{lk: LK_TRIPLE, hk: HK_FULL};
  localparam plane_code_t PC_Q    = '{lk: LK_QUAD,   hk: HK_FULL};
  localparam plane_code_t PC_V    = '{lk: LK_V210,   hk: HK_FULL};

  // Per-format plane layout; element [0] is plane 0
  function automatic plane_code_t plane_code(input logic [FMT_W-1:0] fmt,
                                             input logic [PLANE_W-1:0] idx);
    format_planes_t p;
    case (fmt)
      FMT_I420: p = {PC_NONE, PC_H_HH, PC_H_HH, PC_F};
      FMT_NV12: p = {PC_NONE, PC_NONE, PC_F_HH, PC_F};
      FMT_YVYU: p = {PC_NONE, PC_NONE, PC_NONE, PC_D};
      FMT_YUY2: p = {PC_NONE, PC_NONE, PC_NONE, PC_D};
      FMT_UYVY: p = {PC_NONE, PC_NONE, PC_NONE, PC_D};
      FMT_RGBA: p = {PC_NONE, PC_NONE, PC_NONE, PC_Q};
      FMT_BGRA: p = {PC_NONE, PC_NONE, PC_NONE, PC_Q};
      FMT_BGRX: p = {PC_NONE, PC_NONE, PC_NONE, PC_Q};
      FMT_Y800: p = {PC_NONE, PC_NONE, PC_NONE, PC_F};
      FMT_I444: p = {PC_NONE, PC_F, PC_F, PC_F};
      FMT_BGR3: p = {PC_NONE, PC_NONE, PC_NONE, PC_T};
      FMT_I422: p = {PC_NONE, PC_H, PC_H, PC_F};
      FMT_I40A: p = {PC_F, PC_H_HH, PC_H_HH, PC_F};
      FMT_I42A: p = {PC_F, PC_H, PC_H, PC_F};
      FMT_YUVA: p = {PC_F, PC_F, PC_F, PC_F};
      FMT_AYUV: p = {PC_NONE, PC_NONE, PC_NONE, PC_Q};
      FMT_I010: p = {PC_NONE, PC_F_HH, PC_F_HH, PC_D};
      FMT_P010: p = {PC_NONE, PC_NONE, PC_D_HH, PC_D};
      FMT_I210: p = {PC_NONE, PC_F, PC_F, PC_D};
      FMT_I412: p = {PC_NONE, PC_D, PC_D, PC_D};
      FMT_YA2L: p = {PC_D, PC_D, PC_D, PC_D};
      FMT_P216: p = {PC_NONE, PC_NONE, PC_D, PC_D};
      FMT_P416: p = {PC_NONE, PC_NONE, PC_Q, PC_D};
      FMT_V210: p = {PC_NONE, PC_NONE, PC_NONE, PC_V};
      FMT_R10L: p = {PC_NONE, PC_NONE, PC_NONE, PC_Q};
      default:  p = {PC_NONE, PC_NONE, PC_NONE, PC_NONE};
    endcase
    return p[idx];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vfpl_frame_if.sv -----
`default_nettype none

// Frame description channel
interface vfpl_frame_if;
  logic                          valid;
  logic                          ready;
  logic [vfpl_pkg::FMT_W-1:0]    format_code;
  logic [vfpl_pkg::DIM_W-1:0]    frame_width;
  logic [vfpl_pkg::DIM_W-1:0]    frame_height;

  modport source (output valid, format_code, frame_width, frame_height, input ready);
  modport sink   (input valid, format_code, frame_width, frame_height, output ready);
endinterface

`default_nettype wire

// ----- rtl/vfpl_plane_if.sv -----
`default_nettype none

// Plane layout result channel
interface vfpl_plane_if;
  logic                          valid;
  logic                          ready;
  logic [vfpl_pkg::PLANE_W-1:0]  plane_index;
  logic                          plane_present;
  logic [vfpl_pkg::LINE_W-1:0]   line_bytes;
  logic [vfpl_pkg::ROWS_W-1:0]   plane_rows;
  logic [vfpl_pkg::SIZE_W-1:0]   plane_offset;
  logic [vfpl_pkg::SIZE_W-1:0]   plane_bytes;
  logic [vfpl_pkg::SIZE_W-1:0]   total_bytes;
  logic                          last_plane;

  modport source (output valid, plane_index, plane_present, line_bytes, plane_rows,
                  plane_offset, plane_bytes, total_bytes, last_plane, input ready);
  modport sink   (input valid, plane_index, plane_present, line_bytes, plane_rows,
                  plane_offset, plane_bytes, total_bytes, last_plane, output ready);
endinterface

`default_nettype wire

// ----- rtl/vfpl_line_calc.sv -----
`default_nettype none

// Line size and row count of one plane from its layout code
module vfpl_line_calc (
  input  wire vfpl_pkg::plane_code_t         code,
  input  wire logic [vfpl_pkg::DIM_W-1:0]    width,
  input  wire logic [vfpl_pkg::DIM_W-1:0]    height,
  output vfpl_pkg::line_geom_t               geom
);

  logic [15:0] half_sum;
  logic [15:0] v210_x;
  logic [11:0] v210_y;
  logic [23:0] v210_prod;
  logic [10:0] v210_q;
  logic [17:0] line_raw;

  // V210: ceil(w/48)*48 then /6*16 collapses to ceil(w/48)*128
  assign half_sum  = {1'b0, width} + 16'd1;
  assign v210_x    = {1'b0, width} + 16'd47;
  assign v210_y    = v210_x[15:4];
  assign v210_prod = {12'd0, v210_y} * {12'd0, vfpl_pkg::V210_RECIP};
  assign v210_q    = v210_prod[vfpl_pkg::V210_SHIFT +: 11];

  // Bytes per line, then lines per plane; half height rounds down
  always_comb begin
    case (code.lk)
      vfpl_pkg::LK_FULL:   line_raw = {3'd0, width};
      vfpl_pkg::LK_HALF:   line_raw = {3'd0, half_sum[15:1]};
      vfpl_pkg::LK_DOUBLE: line_raw = {2'd0, width, 1'b0};
      vfpl_pkg::LK_TRIPLE: line_raw = {2'd0, width, 1'b0} + {3'd0, width};
      vfpl_pkg::LK_QUAD:   line_raw = {1'b0, width, 2'd0};
      vfpl_pkg::LK_V210:   line_raw = {v210_q, 7'd0};
      default:             line_raw = '0;
    endcase
    geom.line_bytes = line_raw[17] ? '1 : line_raw[vfpl_pkg::LINE_W-1:0];

    case (code.hk)
      vfpl_pkg::HK_FULL: geom.rows = height;
      vfpl_pkg::HK_HALF: geom.rows = {1'b0, height[vfpl_pkg::DIM_W-1:1]};
      default:           geom.rows = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/video_frame_plane_layout.sv -----
`default_nettype none

// Planar frame buffer layout. Each accepted frame description (format code,
// width, height) yields four plane results, plane 0 first, on the plane
// channel: line size, row count, present flag, byte offset, size rounded up
// to 2^alignment_log2 bytes and the running total. A front sequencer walks
// the four planes of an item, one plane per cycle while stage 1 can load,
// through four register stages (table lookup and line size, line x rows
// product, alignment, running total into the output register). The plane
// sequencer takes the next item in the cycle its predecessor issues its last
// plane. alignment_log2 resets to 5 and values above 12 act as 12; change it
// only while the block is empty.
module video_frame_plane_layout (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [vfpl_pkg::ALGN_W-1:0]     cfg_data,
  vfpl_frame_if.sink                           frame,
  vfpl_plane_if.source                         plane
);

  // Configuration
  logic [vfpl_pkg::ALGN_W-1:0] align_lg;
  logic [vfpl_pkg::ALGN_W-1:0] align_lg_sat;
  logic [11:0]                 align_mask;

  // Sequencer
  logic                          busy;
  logic [vfpl_pkg::PLANE_W-1:0]  cnt;
  logic [vfpl_pkg::FMT_W-1:0]    fmt;
  logic [vfpl_pkg::DIM_W-1:0]    width;
  logic [vfpl_pkg::DIM_W-1:0]    height;
  logic                          issue;
  logic                          take;

  // Stage 1: geometry
  logic                          v1;
  logic [vfpl_pkg::PLANE_W-1:0]  idx1;
  logic                          pres1;
  vfpl_pkg::line_geom_t          geom1;
  vfpl_pkg::line_geom_t          geom_calc;
  vfpl_pkg::plane_code_t         code0;

  // Stage 2: raw size
  logic                          v2;
  logic [vfpl_pkg::PLANE_W-1:0]  idx2;
  logic                          pres2;
  logic [vfpl_pkg::LINE_W-1:0]   lb2;
  logic [vfpl_pkg::ROWS_W-1:0]   rows2;
  logic [vfpl_pkg::SIZE_W-1:0]   prod2;

  // Stage 3: aligned size
  logic                          v3;
  logic [vfpl_pkg::PLANE_W-1:0]  idx3;
  logic                          pres3;
  logic [vfpl_pkg::LINE_W-1:0]   lb3;
  logic [vfpl_pkg::ROWS_W-1:0]   rows3;
  logic [vfpl_pkg::SIZE_W-1:0]   size3;
  logic [vfpl_pkg::SIZE_W-1:0]   size3_next;

  // Output stage and running total
  logic                          vo;
  logic [vfpl_pkg::SIZE_W-1:0]   acc;
  logic [vfpl_pkg::SIZE_W-1:0]   base;
  logic [vfpl_pkg::SIZE_W:0]     sum;
  logic [vfpl_pkg::SIZE_W-1:0]   total_next;

  logic en1, en2, en3, en_o;

  // Stage enables: a stage loads when empty or when its successor moves
  assign en_o = !vo || plane.ready;
  assign en3  = !v3 || en_o;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;

  // Alignment mask
  assign align_lg_sat = (align_lg > vfpl_pkg::ALIGN_LOG2_MAX) ? vfpl_pkg::ALIGN_LOG2_MAX
                                                              : align_lg;
  assign align_mask   = 12'((13'd1 << align_lg_sat) - 13'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      align_lg <= vfpl_pkg::ALIGN_LOG2_RST;
    end else if (cfg_write) begin
      align_lg <= cfg_data;
    end
  end

  // Plane sequencer: holds one item, issues planes 0..3
  assign issue       = busy && en1;
  assign frame.ready = !busy || (issue && cnt == vfpl_pkg::LAST_PLANE);
  assign take        = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (issue) begin
      busy <= (cnt != vfpl_pkg::LAST_PLANE);
      cnt  <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fmt    <= frame.format_code;
      width  <= (frame.frame_width > vfpl_pkg::MAX_DIM) ? vfpl_pkg::MAX_DIM
                                                        : frame.frame_width;
      height <= (frame.frame_height > vfpl_pkg::MAX_DIM) ? vfpl_pkg::MAX_DIM
                                                         : frame.frame_height;
    end
  end

  // Stage 1: layout lookup and line geometry
  assign code0 = vfpl_pkg::plane_code(fmt, cnt);

  vfpl_line_calc u_line_calc (
    .code   (code0),
    .width  (width),
    .height (height),
    .geom   (geom_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      idx1  <= cnt;
      pres1 <= (geom_calc.line_bytes != '0) && (geom_calc.rows != '0);
      geom1 <= geom_calc;
    end
  end

  // Stage 2: line size times rows, absent planes forced to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      idx2  <= idx1;
      pres2 <= pres1;
      lb2   <= pres1 ? geom1.line_bytes : '0;
      rows2 <= pres1 ? geom1.rows : '0;
      prod2 <= {15'd0, geom1.line_bytes} * {17'd0, geom1.rows};
    end
  end

  // Stage 3: round up to alignment (never exceeds 32 bits)
  assign size3_next = pres2 ? ((prod2 + {20'd0, align_mask}) & ~{20'd0, align_mask}) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      idx3  <= idx2;
      pres3 <= pres2;
      lb3   <= lb2;
      rows3 <= rows2;
      size3 <= size3_next;
    end
  end

  // Stage 4: running total, restarted on plane 0, saturating
  assign base       = (idx3 == '0) ? '0 : acc;
  assign sum        = {1'b0, base} + {1'b0, size3};
  assign total_next = sum[vfpl_pkg::SIZE_W] ? '1 : sum[vfpl_pkg::SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en_o) begin
      vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v3) begin
      acc                 <= total_next;
      plane.plane_index   <= idx3;
      plane.plane_present <= pres3;
      plane.line_bytes    <= lb3;
      plane.plane_rows    <= rows3;
      plane.plane_offset  <= pres3 ? base : '0;
      plane.plane_bytes   <= size3;
      plane.total_bytes   <= total_next;
      plane.last_plane    <= (idx3 == vfpl_pkg::LAST_PLANE);
    end
  end

  assign plane.valid = vo;

  // Checks
  a_first_offset : assert property (@(posedge clk) disable iff (rst)
    plane.valid && plane.plane_index == '0 |-> plane.plane_offset == '0)
    else $error("plane 0 offset not zero");

  a_absent_zero : assert property (@(posedge clk) disable iff (rst)
    plane.valid && !plane.plane_present |->
      plane.plane_bytes == '0 && plane.line_bytes == '0 && plane.plane_rows == '0)
    else $error("absent plane carries data");

  a_total_covers : assert property (@(posedge clk) disable iff (rst)
    plane.valid |-> plane.total_bytes >= plane.plane_bytes)
    else $error("running total below plane size");

  a_stage_hold : assert property (@(posedge clk) disable iff (rst)
    v1 && !en1 |=> v1 && $stable(idx1))
    else $error("stalled stage 1 lost its plane");

  a_seq_issue : assert property (@(posedge clk) disable iff (rst)
    issue && cnt != vfpl_pkg::LAST_PLANE |=> busy && cnt == $past(cnt) + 2'd1)
    else $error("plane sequencer skipped a plane");

endmodule

`default_nettype wire

// ----- sim/vfpl_layout_checker.sv -----
// Watches the frame and plane channels, computes the expected plane layout
// for every frame transfer and compares each plane transfer against it.
module vfpl_layout_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [vfpl_pkg::ALGN_W-1:0] cfg_data,
  vfpl_frame_if                       frame,
  vfpl_plane_if                       plane,
  output int                          err_count,
  output int                          pending,
  output int                          planes_seen,
  output int                          present_seen
);

  typedef struct {
    logic [vfpl_pkg::PLANE_W-1:0] index;
    logic                         present;
    logic [vfpl_pkg::LINE_W-1:0]  line_bytes;
    logic [vfpl_pkg::ROWS_W-1:0]  rows;
    logic [vfpl_pkg::SIZE_W-1:0]  offset;
    logic [vfpl_pkg::SIZE_W-1:0]  bytes;
    logic [vfpl_pkg::SIZE_W-1:0]  total;
    logic                         last;
  } plane_layout_t;

  logic [vfpl_pkg::ALGN_W-1:0] align_log2;
  plane_layout_t               expected_planes[$];
  plane_layout_t               want_plane;

  // Four plane layouts of one frame, queued in plane order
  function automatic void push_frame_layout(input logic [vfpl_pkg::FMT_W-1:0] fmt,
                                            input logic [vfpl_pkg::DIM_W-1:0] w_in,
                                            input logic [vfpl_pkg::DIM_W-1:0] h_in);
    vfpl_pkg::line_kind_t        lk [4];
    logic [3:0]                  half_rows;
    logic [63:0]                 w, h, a, lb, rows, s, align, total;
    logic [vfpl_pkg::ALGN_W-1:0] lg;
    plane_layout_t               pl;
    w = (w_in > vfpl_pkg::MAX_DIM) ? 64'(vfpl_pkg::MAX_DIM) : 64'(w_in);
    h = (h_in > vfpl_pkg::MAX_DIM) ? 64'(vfpl_pkg::MAX_DIM) : 64'(h_in);
    lg = (align_log2 > vfpl_pkg::ALIGN_LOG2_MAX) ? vfpl_pkg::ALIGN_LOG2_MAX : align_log2;
    align = 64'd1 << lg;
    total = 64'd0;
    lk = '{vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE};
    half_rows = 4'b0000;
    // per-format plane shapes; half_rows bit i marks a half-height plane i
    case (fmt)
      vfpl_pkg::FMT_I420: begin
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_HALF, vfpl_pkg::LK_HALF,
               vfpl_pkg::LK_NONE};
        half_rows = 4'b0110;
      end
      vfpl_pkg::FMT_NV12: begin
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
        half_rows = 4'b0010;
      end
      vfpl_pkg::FMT_YVYU, vfpl_pkg::FMT_YUY2, vfpl_pkg::FMT_UYVY:
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_RGBA, vfpl_pkg::FMT_BGRA, vfpl_pkg::FMT_BGRX,
      vfpl_pkg::FMT_AYUV, vfpl_pkg::FMT_R10L:
        lk = '{vfpl_pkg::LK_QUAD, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_Y800:
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_I444:
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_BGR3:
        lk = '{vfpl_pkg::LK_TRIPLE, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_I422:
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_HALF, vfpl_pkg::LK_HALF,
               vfpl_pkg::LK_NONE};
      // alpha plane keeps full height
      vfpl_pkg::FMT_I40A: begin
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_HALF, vfpl_pkg::LK_HALF,
               vfpl_pkg::LK_FULL};
        half_rows = 4'b0110;
      end
      vfpl_pkg::FMT_I42A:
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_HALF, vfpl_pkg::LK_HALF,
               vfpl_pkg::LK_FULL};
      vfpl_pkg::FMT_YUVA:
        lk = '{vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL,
               vfpl_pkg::LK_FULL};
      vfpl_pkg::FMT_I010: begin
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL,
               vfpl_pkg::LK_NONE};
        half_rows = 4'b0110;
      end
      vfpl_pkg::FMT_P010: begin
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
        half_rows = 4'b0010;
      end
      vfpl_pkg::FMT_I210:
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_FULL, vfpl_pkg::LK_FULL,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_I412:
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_DOUBLE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_YA2L:
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_DOUBLE,
               vfpl_pkg::LK_DOUBLE};
      vfpl_pkg::FMT_P216:
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_P416:
        lk = '{vfpl_pkg::LK_DOUBLE, vfpl_pkg::LK_QUAD, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      vfpl_pkg::FMT_V210:
        lk = '{vfpl_pkg::LK_V210, vfpl_pkg::LK_NONE, vfpl_pkg::LK_NONE,
               vfpl_pkg::LK_NONE};
      default: ;  // none and unknown codes: nothing present
    endcase
    for (int i = 0; i < 4; i++) begin
      case (lk[i])
        vfpl_pkg::LK_FULL:   lb = w;
        vfpl_pkg::LK_HALF:   lb = (w + 64'd1) / 64'd2;
        vfpl_pkg::LK_DOUBLE: lb = w * 64'd2;
        vfpl_pkg::LK_TRIPLE: lb = w * 64'd3;
        vfpl_pkg::LK_QUAD:   lb = w * 64'd4;
        vfpl_pkg::LK_V210: begin
          a = ((w + 64'd47) / 64'd48) * 64'd48;
          lb = ((a + 64'd5) / 64'd6) * 64'd16;
        end
        default:   lb = 64'd0;
      endcase
      if (lb > 64'h1FFFF) lb = 64'h1FFFF;
      rows = half_rows[i] ? h / 64'd2 : h;
      if (rows > 64'h7FFF) rows = 64'h7FFF;
      pl.index = i[vfpl_pkg::PLANE_W-1:0];
      pl.present = (lb != 64'd0) && (rows != 64'd0);
      pl.line_bytes = '0;
      pl.rows = '0;
      pl.offset = '0;
      pl.bytes = '0;
      // absent planes leave the running total untouched
      if (pl.present) begin
        s = lb * rows;
        s = (s + align - 64'd1) & ~(align - 64'd1);
        pl.line_bytes = lb[vfpl_pkg::LINE_W-1:0];
        pl.rows = rows[vfpl_pkg::ROWS_W-1:0];
        pl.offset = total[vfpl_pkg::SIZE_W-1:0];
        pl.bytes = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[vfpl_pkg::SIZE_W-1:0];
        total = total + s;
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      end
      pl.total = total[vfpl_pkg::SIZE_W-1:0];
      pl.last = (i == 3);
      expected_planes.push_back(pl);
    end
  endfunction

  // One field compare; returns 1 on mismatch
  function automatic int field_diff(input string name, input logic [63:0] want_v,
                                    input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      align_log2 = vfpl_pkg::ALIGN_LOG2_RST;
      expected_planes.delete();
      err_count = 0;
      planes_seen = 0;
      present_seen = 0;
    end else begin
      if (plane.valid && plane.ready) begin
        if (expected_planes.size() == 0) begin
          $error("plane transfer with nothing expected (plane_index %0d)",
                 plane.plane_index);
          err_count++;
        end else begin
          want_plane = expected_planes.pop_front();
          err_count += field_diff("plane_index", want_plane.index, plane.plane_index)
                     + field_diff("plane_present", want_plane.present, plane.plane_present)
                     + field_diff("line_bytes", want_plane.line_bytes, plane.line_bytes)
                     + field_diff("plane_rows", want_plane.rows, plane.plane_rows)
                     + field_diff("plane_offset", want_plane.offset, plane.plane_offset)
                     + field_diff("plane_bytes", want_plane.bytes, plane.plane_bytes)
                     + field_diff("total_bytes", want_plane.total, plane.total_bytes)
                     + field_diff("last_plane", want_plane.last, plane.last_plane);
          planes_seen++;
          if (want_plane.present) present_seen++;
        end
      end
      if (frame.valid && frame.ready)
        push_frame_layout(frame.format_code, frame.frame_width, frame.frame_height);
      if (cfg_write) align_log2 = cfg_data;
    end
    pending = expected_planes.size();
  end

endmodule

// ----- sim/tb_video_frame_plane_layout.sv -----
// Stimulus and verdict; checking lives in vfpl_layout_checker.
module tb_video_frame_plane_layout;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 58;
  localparam int NUM_PHASES     = 6;

  typedef enum logic [1:0] {
    PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH
  } pace_t;

  typedef logic [vfpl_pkg::FMT_W-1:0]  fmt_t;
  typedef logic [vfpl_pkg::DIM_W-1:0]  dim_t;
  typedef logic [vfpl_pkg::ALGN_W-1:0] algn_t;

  typedef struct {
    fmt_t fmt;
    dim_t width;
    dim_t height;
  } frame_desc_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  algn_t             cfg_data;
  logic              took;
  pace_t             pace;
  frame_desc_t       frame_queue[$];
  frame_desc_t       next_frame;
  int                err_count, pending, planes_seen, present_seen;
  int                frames_sent, align_writes;

  vfpl_frame_if frame_ch ();
  vfpl_plane_if plane_ch ();

  video_frame_plane_layout u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .frame     (frame_ch),
    .plane     (plane_ch)
  );

  vfpl_layout_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .frame        (frame_ch),
    .plane        (plane_ch),
    .err_count    (err_count),
    .pending      (pending),
    .planes_seen  (planes_seen),
    .present_seen (present_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // 45% idle for the side the pace names, 16% for both sides
  function automatic bit idle_now(input pace_t mode, input pace_t own);
    int roll;
    roll = $urandom_range(99);
    if (mode == own) return roll < 45;
    if (mode == PACE_BOTH) return roll < 16;
    return 1'b0;
  endfunction

  // Mostly small sizes, plenty around the clip point, some full-range
  function automatic dim_t rand_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return dim_t'($urandom_range(0, 64));
    if (roll < 50) return dim_t'($urandom_range(65, 4000));
    if (roll < 65) return dim_t'($urandom_range(16370, 16400));
    if (roll < 75) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return dim_t'(1);
        2:       return vfpl_pkg::MAX_DIM;
        default: return '1;
      endcase
    end
    return dim_t'($urandom_range(0, 32767));
  endfunction

  // Wait until nothing is queued, in flight or expected
  task automatic wait_drained();
    while (frame_queue.size() != 0 || frame_ch.valid || pending != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_alignment(input algn_t value);
    wait_drained();
    cfg_data = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    align_writes++;
  endtask

  task automatic queue_frame(input fmt_t fmt, input dim_t w, input dim_t h);
    frame_desc_t d;
    d.fmt = fmt;
    d.width = w;
    d.height = h;
    frame_queue.push_back(d);
  endtask

  always @(posedge clk) took <= frame_ch.valid && frame_ch.ready;

  // Frame driver: hold until transfer, then next item or a gap
  always @(negedge clk) begin
    if (!frame_ch.valid || took) begin
      if (frame_queue.size() != 0 && !idle_now(pace, PACE_SEND_GAPS)) begin
        next_frame = frame_queue.pop_front();
        frame_ch.format_code = next_frame.fmt;
        frame_ch.frame_width = next_frame.width;
        frame_ch.frame_height = next_frame.height;
        frame_ch.valid = 1'b1;
        frames_sent++;
      end else begin
        frame_ch.valid = 1'b0;
      end
    end
  end

  // Plane receiver backpressure
  always @(negedge clk) plane_ch.ready = !idle_now(pace, PACE_RECV_STALLS);

  // Watchdog: too long without any transfer ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((frame_ch.valid && frame_ch.ready) || (plane_ch.valid && plane_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_video_frame_plane_layout: done, errors");
    $finish;
  end

  initial begin
    dim_t  w_pick [8];
    dim_t  h_pick [8];
    algn_t phase_align [NUM_PHASES];
    pace_t phase_pace [NUM_PHASES];
    fmt_t  fmt;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    frame_ch.valid = 1'b0;
    frame_ch.format_code = '0;
    frame_ch.frame_width = '0;
    frame_ch.frame_height = '0;
    plane_ch.ready = 1'b0;
    pace = PACE_FULL;
    frames_sent = 0;
    align_writes = 0;
    w_pick = '{15'd0, 15'd1, 15'd2, 15'd47, 15'd49, 15'd16383, 15'd16384, 15'd32767};
    h_pick = '{15'd1, 15'd0, 15'd3, 15'd16384, 15'd2, 15'd32767, 15'd16385, 15'd5};
    phase_align = '{4'd0, 4'd15, 4'd12, 4'd1, 4'd9, algn_t'($urandom_range(2, 11))};
    phase_pace = '{PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH,
                   PACE_RECV_STALLS, PACE_BOTH};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every format at reset alignment, sizes from the edges
    for (int f = 1; f <= 25; f++)
      queue_frame(fmt_t'(f), w_pick[(f + 1) % 8], h_pick[f % 8]);
    // one-line I40A: chroma drops out, alpha still follows luma
    queue_frame(vfpl_pkg::FMT_I40A, 15'd3, 15'd1);
    queue_frame(vfpl_pkg::FMT_V210, 15'd32767, 15'd3);
    queue_frame(vfpl_pkg::FMT_NONE, 15'd32767, 15'd32767);
    queue_frame(5'd31, 15'd16384, 15'd16384);
    queue_frame(5'd26, 15'd100, 15'd7);

    // random phases, each with its own alignment and pacing
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_alignment(phase_align[p]);
      pace = phase_pace[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        fmt = ($urandom_range(99) < 90) ? fmt_t'($urandom_range(1, 25))
                                        : fmt_t'($urandom_range(0, 31));
        queue_frame(fmt, rand_dim(), rand_dim());
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("covered %0d frame descriptions, all formats and unknown codes,",
             frames_sent);
    $display("%0d alignment writes; checked %0d plane results, %0d present",
             align_writes, planes_seen, present_seen);
    if (err_count == 0 && pending == 0)
      $display("tb_video_frame_plane_layout: done, clean");
    else
      $display("tb_video_frame_plane_layout: done, errors");
    $finish;
  end

endmodule
